@@ src/gta_pkg.sv @@
// Shared constants, types and helpers of the GEMM tile accumulator.
package gta_pkg;

  localparam int TILE_SIZE  = 4;
  localparam int DATA_BITS  = 16;
  localparam int ACC_BITS   = 48;
  localparam int PROD_BITS  = 2 * DATA_BITS;
  localparam int SUM_BITS   = ACC_BITS + 1;
  localparam int ROW_BITS   = $clog2(TILE_SIZE);
  localparam int FIFO_DEPTH = TILE_SIZE;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [DATA_BITS-1:0] data_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic [ROW_BITS-1:0]         row_idx_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // One k step as it travels down the row of cells
  typedef struct packed {
    logic                       valid;
    logic                       first;
    logic                       last;
    data_t [TILE_SIZE-1:0]      x;
    data_t [TILE_SIZE-1:0]      y;
  } word_t;

  // One finished tile row
  typedef struct packed {
    row_idx_t                   tile_row;
    acc_t [TILE_SIZE-1:0]       sum;
    logic                       tile_done;
  } res_t;

endpackage

@@ src/gta_if.sv @@
// Stream interfaces for the step words in and the tile row words out.
interface gta_in_if
  import gta_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t x_row0;
  data_t x_row1;
  data_t x_row2;
  data_t x_row3;
  data_t y_col0;
  data_t y_col1;
  data_t y_col2;
  data_t y_col3;
  logic  first_step;
  logic  last_step;

  modport source (
    output valid, x_row0, x_row1, x_row2, x_row3,
    output y_col0, y_col1, y_col2, y_col3, first_step, last_step,
    input  ready
  );
  modport sink (
    input  valid, x_row0, x_row1, x_row2, x_row3,
    input  y_col0, y_col1, y_col2, y_col3, first_step, last_step,
    output ready
  );
endinterface

interface gta_out_if
  import gta_pkg::*;
();
  logic     valid;
  logic     ready;
  row_idx_t tile_row;
  acc_t     sum0;
  acc_t     sum1;
  acc_t     sum2;
  acc_t     sum3;
  logic     tile_done;

  modport source (
    output valid, tile_row, sum0, sum1, sum2, sum3, tile_done,
    input  ready
  );
  modport sink (
    input  valid, tile_row, sum0, sum1, sum2, sum3, tile_done,
    output ready
  );
endinterface

@@ src/gta_cell.sv @@
// One tile row cell: multiplies, saturating accumulate, forwards the step word.
module gta_cell
  import gta_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  word_t                word_i,
  output word_t                word_o,
  output logic                 res_valid_o,
  output acc_t [TILE_SIZE-1:0] acc_o
);

  function automatic acc_t sat_add(acc_t a, prod_t p);
    logic signed [SUM_BITS-1:0] s;
    s = $signed({a[ACC_BITS-1], a}) +
        $signed({{(SUM_BITS-PROD_BITS){p[PROD_BITS-1]}}, p});
    if (s[SUM_BITS-1] != s[SUM_BITS-2]) begin
      return s[SUM_BITS-1] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_BITS-1:0];
  endfunction

  word_t                 word_q;
  prod_t [TILE_SIZE-1:0] prod_q;
  logic                  s1_valid_q;
  logic                  s1_first_q;
  logic                  s1_last_q;
  acc_t [TILE_SIZE-1:0]  acc_q;
  acc_t [TILE_SIZE-1:0]  acc_d;
  logic                  res_valid_q;
  word_t                 fwd_d;

  // Drop this row's x and move the rest down one place for the next cell
  always_comb begin
    fwd_d = word_i;
    fwd_d.x = {data_t'(0), word_i.x[TILE_SIZE-1:1]};
  end

  // Saturating accumulate, cleared first on a first step
  always_comb begin
    for (int j = 0; j < TILE_SIZE; j++) begin
      acc_d[j] = sat_add(s1_first_q ? acc_t'(0) : acc_q[j], prod_q[j]);
    end
  end

  // Control, forwarded word and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q       <= '0;
      s1_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      acc_q        <= '0;
    end else if (adv_i) begin
      word_q       <= fwd_d;
      s1_valid_q   <= word_i.valid;
      res_valid_q  <= s1_valid_q && s1_last_q;
      if (s1_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  // Payload: step flags and products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_first_q   <= word_i.first;
      s1_last_q    <= word_i.last;
      for (int j = 0; j < TILE_SIZE; j++) begin
        prod_q[j] <= $signed(word_i.x[0]) * $signed(word_i.y[j]);
      end
    end
  end

  assign word_o      = word_q;
  assign res_valid_o = res_valid_q;
  assign acc_o       = acc_q;

endmodule

@@ src/gta_fifo.sv @@
// Output queue of finished tile rows, drives the result channel.
module gta_fifo
  import gta_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  res_t          push_data_i,
  output logic          full_o,
  gta_out_if.source     out_o
);

  res_t                mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q;
  logic [PTR_BITS-1:0] rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic                pop;
  res_t                head;

  assign pop    = out_o.valid && out_o.ready;
  assign full_o = (count_q == CNT_BITS'(FIFO_DEPTH));
  assign head   = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store pushed rows
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_o.valid     = (count_q != '0);
  assign out_o.tile_row  = head.tile_row;
  assign out_o.sum0      = head.sum[0];
  assign out_o.sum1      = head.sum[1];
  assign out_o.sum2      = head.sum[2];
  assign out_o.sum3      = head.sum[3];
  assign out_o.tile_done = head.tile_done;

endmodule

@@ src/gemm_tile_4x4_accumulator.sv @@
// Top level of the 4x4 outer-product GEMM tile accumulator.
//
// in_i carries one k step per word: four X values (one per tile row), four
// Y values (one per tile column), first_step and last_step. out_o carries
// one finished tile row per word: tile_row, sum0..sum3 and tile_done, which
// is set on row 3.
// The step word runs down a row of four cells, one cell per tile row, one
// cell per cycle while the cells advance. Each cell multiplies in one stage
// and does the 48-bit saturating accumulate in the next. Row r of a tile
// enters the output queue after row r - 1, so the tile leaves in row order,
// one row per cycle while out_o.ready stays high. Throughput: one step per
// cycle while the output queue has room. A step with last_step set is held
// off after the previous last step until the gap counter runs down, since
// the queue takes only one finished row at a time.
// Reset clears all accumulators to zero and empties the output queue.
// A four-row queue holds results while the receiver stalls; steps keep
// being accepted until it fills, then the cells freeze and in_i.ready drops.
module gemm_tile_4x4_accumulator
  import gta_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gta_in_if.sink    in_i,
  gta_out_if.source out_o
);

  word_t                 chain [TILE_SIZE+1];
  logic [TILE_SIZE-1:0]  res_valid;
  acc_t [TILE_SIZE-1:0]  row_acc [TILE_SIZE];
  logic                  adv;
  logic                  fifo_full;
  logic                  in_acc;
  logic [ROW_BITS-1:0]   gap_q;
  res_t                  push_data;

  // Freeze the cells only when the output queue has no room
  assign adv       = !fifo_full;
  assign in_i.ready = adv && ((gap_q == '0) || !in_i.last_step);
  assign in_acc    = in_i.valid && in_i.ready;

  // Build the step word entering the first cell
  always_comb begin
    chain[0].valid = in_acc;
    chain[0].first = in_i.first_step;
    chain[0].last  = in_i.last_step;
    chain[0].x     = {in_i.x_row3, in_i.x_row2, in_i.x_row1, in_i.x_row0};
    chain[0].y     = {in_i.y_col3, in_i.y_col2, in_i.y_col1, in_i.y_col0};
  end

  // Count advances since the last accepted last step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (adv) begin
      if (in_acc && in_i.last_step) begin
        gap_q <= ROW_BITS'(TILE_SIZE - 1);
      end else if (gap_q != '0) begin
        gap_q <= gap_q - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < TILE_SIZE; i++) begin : g_cell
    gta_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .word_i      (chain[i]),
      .word_o      (chain[i+1]),
      .res_valid_o (res_valid[i]),
      .acc_o       (row_acc[i])
    );
  end

  // Select the one cell holding a finished row
  always_comb begin
    push_data = '0;
    for (int i = 0; i < TILE_SIZE; i++) begin
      if (res_valid[i]) begin
        push_data.tile_row  = ROW_BITS'(i);
        push_data.sum       = row_acc[i];
        push_data.tile_done = (i == TILE_SIZE - 1);
      end
    end
  end

  gta_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv && (res_valid != '0)),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  a_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(res_valid))
    else $error("two cells hold a finished row at once");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last_step) |=> !(in_acc && in_i.last_step))
    else $error("last steps accepted too close together");

  a_tail_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain[TILE_SIZE].valid && chain[TILE_SIZE].last) |-> (gap_q == '0))
    else $error("last step left the chain with the gap counter still running");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid != '0) && !adv |=> $stable(res_valid))
    else $error("finished row lost while the queue was full");
`endif

endmodule
